>>> sv/assert_macros.svh
// assertion macros for the drude cell update block
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define DCU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication checked on every clock edge outside reset
`define DCU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/dcu_pkg.sv
// shared types, constants, exponential tables and saturation helpers
// no dependencies; used by every other file of the block except assert_macros.svh
package dcu_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int DEPTH_BITS      = $clog2(EXP_TABLE_DEPTH);
	localparam int EXP_INT_SPAN    = 32;
	localparam int INT_BITS        = $clog2(EXP_INT_SPAN);
	localparam int NSTAGE          = 11;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF    = 64'd1 << (FRAC_BITS - 1);

	// e^(-1/depth) as a six-term series
	localparam logic [63:0] STEP_T1 = Q30_ONE / (64'd1 * 64'(EXP_TABLE_DEPTH));
	localparam logic [63:0] STEP_T2 = STEP_T1 / (64'd2 * 64'(EXP_TABLE_DEPTH));
	localparam logic [63:0] STEP_T3 = STEP_T2 / (64'd3 * 64'(EXP_TABLE_DEPTH));
	localparam logic [63:0] STEP_T4 = STEP_T3 / (64'd4 * 64'(EXP_TABLE_DEPTH));
	localparam logic [63:0] STEP_T5 = STEP_T4 / (64'd5 * 64'(EXP_TABLE_DEPTH));
	localparam logic [63:0] STEP_T6 = STEP_T5 / (64'd6 * 64'(EXP_TABLE_DEPTH));
	localparam logic [63:0] EXP_STEP_RATIO = Q30_ONE - STEP_T1 + STEP_T2 - STEP_T3
		+ STEP_T4 - STEP_T5 + STEP_T6;

	// e^-1 as a sixteen-term series
	localparam logic [63:0] NEG1_T1  = Q30_ONE / 64'd1;
	localparam logic [63:0] NEG1_T2  = NEG1_T1 / 64'd2;
	localparam logic [63:0] NEG1_T3  = NEG1_T2 / 64'd3;
	localparam logic [63:0] NEG1_T4  = NEG1_T3 / 64'd4;
	localparam logic [63:0] NEG1_T5  = NEG1_T4 / 64'd5;
	localparam logic [63:0] NEG1_T6  = NEG1_T5 / 64'd6;
	localparam logic [63:0] NEG1_T7  = NEG1_T6 / 64'd7;
	localparam logic [63:0] NEG1_T8  = NEG1_T7 / 64'd8;
	localparam logic [63:0] NEG1_T9  = NEG1_T8 / 64'd9;
	localparam logic [63:0] NEG1_T10 = NEG1_T9 / 64'd10;
	localparam logic [63:0] NEG1_T11 = NEG1_T10 / 64'd11;
	localparam logic [63:0] NEG1_T12 = NEG1_T11 / 64'd12;
	localparam logic [63:0] NEG1_T13 = NEG1_T12 / 64'd13;
	localparam logic [63:0] NEG1_T14 = NEG1_T13 / 64'd14;
	localparam logic [63:0] NEG1_T15 = NEG1_T14 / 64'd15;
	localparam logic [63:0] NEG1_T16 = NEG1_T15 / 64'd16;
	localparam logic [63:0] EXP_NEG_ONE = Q30_ONE - NEG1_T1 + NEG1_T2 - NEG1_T3
		+ NEG1_T4 - NEG1_T5 + NEG1_T6 - NEG1_T7 + NEG1_T8 - NEG1_T9 + NEG1_T10
		- NEG1_T11 + NEG1_T12 - NEG1_T13 + NEG1_T14 - NEG1_T15 + NEG1_T16;

	localparam int XP_W    = 62;
	localparam int DECAY_W = FRAC_BITS + 1;
	localparam int DTF_W   = 64 - FRAC_BITS;
	localparam int AF_W    = 65 - FRAC_BITS;
	localparam int BC_W    = 68 - FRAC_BITS;
	localparam int DP_W    = DECAY_W + 33;
	localparam int DR_W    = DP_W - FRAC_BITS;
	localparam int FR_W    = 64 - FRAC_BITS;
	localparam int SUM_W   = BC_W + 2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FACE_SIGN = 1'b1;

	typedef logic [30:0] q30_t;
	typedef q30_t step_rom_t [EXP_TABLE_DEPTH+1];
	typedef q30_t int_rom_t [EXP_INT_SPAN];

	typedef struct packed {
		logic signed [31:0] field_old;
		logic signed [31:0] aux_old;
		logic [30:0]        decay_rate;
		logic signed [31:0] coeff_a;
		logic signed [31:0] coeff_b;
		logic signed [31:0] coeff_f;
		logic signed [31:0] p_center;
		logic signed [31:0] p_back;
		logic signed [31:0] q_center;
		logic signed [31:0] q_back;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] field_new;
		logic signed [31:0] aux_new;
		logic               saturated;
	} rsp_item_t;

	typedef struct packed {
		logic [NSTAGE-1:0] load;
		logic [NSTAGE-1:0] valid;
	} pipe_ctrl_t;

	typedef struct packed {
		logic signed [31:0]      aux;
		logic signed [31:0]      cf;
		logic signed [DTF_W-1:0] dtf;
		logic signed [AF_W-1:0]  af;
		logic signed [BC_W-1:0]  bc;
	} carry_t;

	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b + (Q30_ONE >> 1);
		return p >> 30;
	endfunction

	function automatic step_rom_t build_step_rom();
		step_rom_t   r;
		logic [63:0] s;
		logic [63:0] v;
		s = EXP_STEP_RATIO;
		r[0] = Q30_ONE[30:0];
		for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
			v = q30_mul(64'(r[i-1]), s);
			r[i] = v[30:0];
		end
		return r;
	endfunction

	function automatic int_rom_t build_int_rom();
		int_rom_t    r;
		logic [63:0] s;
		logic [63:0] v;
		s = EXP_NEG_ONE;
		r[0] = Q30_ONE[30:0];
		for (int i = 1; i < EXP_INT_SPAN; i++) begin
			v = q30_mul(64'(r[i-1]), s);
			r[i] = v[30:0];
		end
		return r;
	endfunction

	localparam step_rom_t EXP_STEP_ROM = build_step_rom();
	localparam int_rom_t  EXP_INT_ROM  = build_int_rom();

	function automatic logic is_clip(input logic signed [SUM_W-1:0] v);
		return !((&v[SUM_W-1:31]) || (~|v[SUM_W-1:31]));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		if (is_clip(v))
			return v[SUM_W-1] ? 32'sh80000000 : 32'sh7fffffff;
		return v[31:0];
	endfunction

endpackage

>>> sv/dcu_if.sv
// valid/ready channel interfaces for cell items and results
// depends on dcu_pkg
interface dcu_req_if import dcu_pkg::*;;
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dcu_rsp_if import dcu_pkg::*;;
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/dcu_flow.sv
// stage valid bits and per-stage load enables of the update pipeline
// depends on dcu_pkg; bubbles collapse while the output is stalled
module dcu_flow import dcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output pipe_ctrl_t ctrl
);

	logic [NSTAGE-1:0] valid_q;
	logic [NSTAGE-1:0] load;

	always_comb begin
		load[NSTAGE-1] = !valid_q[NSTAGE-1] || out_ready;
		for (int i = NSTAGE - 2; i >= 0; i--)
			load[i] = !valid_q[i] || load[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0])
				valid_q[0] <= in_valid;
			for (int i = 1; i < NSTAGE; i++)
				if (load[i])
					valid_q[i] <= valid_q[i-1];
		end
	end

	assign ctrl.load  = load;
	assign ctrl.valid = valid_q;

endmodule

>>> sv/dcu_decay.sv
// pipelined exp(-dt*gamma) from the raw dt*gamma product
// depends on dcu_pkg tables; occupies stages three to seven
module dcu_decay import dcu_pkg::*; (
	input  logic               clk,
	input  pipe_ctrl_t         ctrl,
	input  logic [XP_W-1:0]    xprod,
	output logic [DECAY_W-1:0] decay
);

	logic [XP_W-1:0]            x_rnd;
	logic [XP_W-FRAC_BITS-1:0]  x_c;
	logic [DEPTH_BITS-1:0]      f_c;
	logic [DEPTH_BITS:0]        f_idx;
	logic [DEPTH_BITS:0]        f_nxt;
	logic [INT_BITS-1:0]        n_c;
	logic [FRAC_BITS-1:0]       rem_c;
	logic [61:0]                comb_t;
	logic [31:0]                comb_r;
	logic [31:0]                comb_h;

	logic [30:0]            t0_s3, diff_s3, ei_s3;
	logic [FRAC_BITS-1:0]   rem_s3;
	logic                   zero_s3;
	logic [46:0]            mp_s4;
	logic [30:0]            t0_s4, ei_s4;
	logic                   zero_s4;
	logic [30:0]            interp_s5, ei_s5;
	logic                   zero_s5;
	logic [61:0]            cp_s6;
	logic                   zero_s6;
	logic [DECAY_W-1:0]     decay_s7;

	always_comb begin
		x_rnd = xprod + XP_W'(HALF);
		x_c   = x_rnd[XP_W-1:FRAC_BITS];
		n_c   = x_c[FRAC_BITS +: INT_BITS];
		f_c   = x_c[FRAC_BITS-DEPTH_BITS +: DEPTH_BITS];
		rem_c = {x_c[FRAC_BITS-DEPTH_BITS-1:0], {DEPTH_BITS{1'b0}}};
		f_idx = {1'b0, f_c};
		f_nxt = f_idx + {{DEPTH_BITS{1'b0}}, 1'b1};
	end

	always_comb begin
		comb_t = cp_s6 + 62'(Q30_ONE >> 1);
		comb_r = comb_t[61:30];
		comb_h = comb_r + 32'(64'd1 << (29 - FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			t0_s3   <= EXP_STEP_ROM[f_idx];
			diff_s3 <= EXP_STEP_ROM[f_idx] - EXP_STEP_ROM[f_nxt];
			ei_s3   <= EXP_INT_ROM[n_c];
			rem_s3  <= rem_c;
			zero_s3 <= (x_c >> (FRAC_BITS + INT_BITS)) != '0;
		end
		if (ctrl.load[3]) begin
			mp_s4   <= diff_s3 * rem_s3;
			t0_s4   <= t0_s3;
			ei_s4   <= ei_s3;
			zero_s4 <= zero_s3;
		end
		if (ctrl.load[4]) begin
			interp_s5 <= t0_s4 - mp_s4[FRAC_BITS +: 31];
			ei_s5     <= ei_s4;
			zero_s5   <= zero_s4;
		end
		if (ctrl.load[5]) begin
			cp_s6   <= ei_s5 * interp_s5;
			zero_s6 <= zero_s5;
		end
		if (ctrl.load[6])
			decay_s7 <= zero_s6 ? '0 : comb_h[30-FRAC_BITS +: DECAY_W];
	end

	assign decay = decay_s7;

endmodule

>>> sv/fdtd_drude_cell_update.sv
// drude cell update: each item passes stage registers s1 to s11 from input transfer to result valid
// throughput one item per cycle while the output is not stalled; set by the eleven-stage multiplier pipeline
// a stalled output holds its result while empty stages ahead still fill
// arst_n clears all stage valid bits, time_step and face_sign
`include "assert_macros.svh"
module fdtd_drude_cell_update import dcu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [30:0]          cfg_data,
	dcu_req_if.sink              req,
	dcu_rsp_if.source            rsp
);

	logic [30:0] time_step_q;
	logic        face_sign_q;
	pipe_ctrl_t  ctrl;
	logic [DECAY_W-1:0] decay;

	logic signed [34:0] curl_c;
	logic signed [32:0] sb_c;
	logic [63:0]        dtf_t;
	logic [AF_W+FRAC_BITS-1:0] af_t;
	logic [BC_W+FRAC_BITS-1:0] bc_t;
	logic [DP_W-1:0]    dr_t;
	logic signed [DR_W-1:0] dr_c;
	logic signed [SUM_W-1:0] asum_c;
	logic [63:0]        fr_t;
	logic signed [FR_W-1:0] fr_c;
	logic signed [SUM_W-1:0] fsum_c;

	logic signed [31:0] field_s1, aux_s1, ca_s1, cb_s1, cf_s1;
	logic [30:0]        gamma_s1;
	logic signed [34:0] curl_s1;
	logic [XP_W-1:0]    xprod_s2;
	logic signed [63:0] dtf_s2;
	logic signed [AF_W+FRAC_BITS-1:0] af_s2;
	logic signed [BC_W+FRAC_BITS-1:0] bc_s2;
	logic signed [31:0] aux_s2, cf_s2;
	carry_t             c_s3, c_s4, c_s5, c_s6, c_s7, c_s8;
	logic signed [DP_W-1:0] dprod_s8;
	logic signed [31:0] aux_new_s9, cf_s9;
	logic               clip_s9;
	logic signed [AF_W-1:0] af_s9, af_s10;
	logic signed [BC_W-1:0] bc_s9, bc_s10;
	logic signed [63:0] fp_s10;
	logic signed [31:0] aux_new_s10;
	logic               clip_s10;
	rsp_item_t          out_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			face_sign_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data;
				REG_FACE_SIGN: face_sign_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dcu_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.ctrl      (ctrl)
	);

	dcu_decay u_decay (
		.clk   (clk),
		.ctrl  (ctrl),
		.xprod (xprod_s2),
		.decay (decay)
	);

	assign req.ready = ctrl.load[0];
	assign rsp.valid = ctrl.valid[NSTAGE-1];
	assign rsp.data  = out_s11;

	always_comb begin
		curl_c = (35'(req.data.p_center) - 35'(req.data.p_back))
			- (35'(req.data.q_center) - 35'(req.data.q_back));
		sb_c   = face_sign_q ? 33'(cb_s1) : 33'sd0 - 33'(cb_s1);
		dtf_t  = dtf_s2 + 64'(HALF);
		af_t   = af_s2 + (AF_W+FRAC_BITS)'(HALF);
		bc_t   = bc_s2 + (BC_W+FRAC_BITS)'(HALF);
		dr_t   = dprod_s8 + DP_W'(HALF);
		dr_c   = $signed(dr_t[DP_W-1:FRAC_BITS]);
		asum_c = SUM_W'(c_s8.dtf) + SUM_W'(dr_c);
		fr_t   = fp_s10 + 64'(HALF);
		fr_c   = $signed(fr_t[63:FRAC_BITS]);
		fsum_c = SUM_W'(af_s10) + SUM_W'(bc_s10) - SUM_W'(fr_c);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			field_s1 <= req.data.field_old;
			aux_s1   <= req.data.aux_old;
			gamma_s1 <= req.data.decay_rate;
			ca_s1    <= req.data.coeff_a;
			cb_s1    <= req.data.coeff_b;
			cf_s1    <= req.data.coeff_f;
			curl_s1  <= curl_c;
		end
		if (ctrl.load[1]) begin
			xprod_s2 <= time_step_q * gamma_s1;
			dtf_s2   <= $signed({1'b0, time_step_q}) * field_s1;
			af_s2    <= $signed({ca_s1, 1'b0}) * field_s1;
			bc_s2    <= sb_c * curl_s1;
			aux_s2   <= aux_s1;
			cf_s2    <= cf_s1;
		end
		if (ctrl.load[2]) begin
			c_s3.aux <= aux_s2;
			c_s3.cf  <= cf_s2;
			c_s3.dtf <= dtf_t[63:FRAC_BITS];
			c_s3.af  <= af_t[AF_W+FRAC_BITS-1:FRAC_BITS];
			c_s3.bc  <= bc_t[BC_W+FRAC_BITS-1:FRAC_BITS];
		end
		if (ctrl.load[3])
			c_s4 <= c_s3;
		if (ctrl.load[4])
			c_s5 <= c_s4;
		if (ctrl.load[5])
			c_s6 <= c_s5;
		if (ctrl.load[6])
			c_s7 <= c_s6;
		if (ctrl.load[7]) begin
			dprod_s8 <= $signed({1'b0, decay}) * c_s7.aux;
			c_s8     <= c_s7;
		end
		if (ctrl.load[8]) begin
			aux_new_s9 <= sat32(asum_c);
			clip_s9    <= is_clip(asum_c);
			cf_s9      <= c_s8.cf;
			af_s9      <= c_s8.af;
			bc_s9      <= c_s8.bc;
		end
		if (ctrl.load[9]) begin
			fp_s10      <= cf_s9 * aux_new_s9;
			aux_new_s10 <= aux_new_s9;
			clip_s10    <= clip_s9;
			af_s10      <= af_s9;
			bc_s10      <= bc_s9;
		end
		if (ctrl.load[10]) begin
			out_s11.field_new <= sat32(fsum_c);
			out_s11.aux_new   <= aux_new_s10;
			out_s11.saturated <= clip_s10 | is_clip(fsum_c);
		end
	end

	`DCU_ASSERT_IMPL(a_sat_flag, rsp.valid && rsp.data.saturated, (rsp.data.field_new == 32'sh7fffffff || rsp.data.field_new == 32'sh80000000 || rsp.data.aux_new == 32'sh7fffffff || rsp.data.aux_new == 32'sh80000000), "saturated flag without a clipped result")
	`DCU_ASSERT_IMPL(a_stall_src, !req.ready, rsp.valid && !rsp.ready, "input stalled while output free")
	`DCU_ASSERT(a_decay_max, !ctrl.valid[6] || decay <= DECAY_W'(64'd1 << FRAC_BITS), "decay factor above one")

endmodule
